// File: rtl/mcorf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcorf_pkg
// Shared types and constants of the multichannel overwrite ring FIFO:
// item modes, register indexes and the command passed from front to back.
// ----------------------------------------------------------------------------
package mcorf_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int LANES      = 4;
  localparam int MODE_W     = 2;
  localparam int FRAMES_W   = 11;
  localparam int COUNT_W    = 32;
  localparam int CHAN_W     = 3;
  localparam int ADDR_MAX_W = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;

  localparam logic [FRAMES_W-1:0] DELIVERED_MAX = '1;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNELS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY = 1'd1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ
  } op_t;

  typedef struct packed {
    logic [FRAMES_W-1:0] frames_delivered;
    logic [FRAMES_W-1:0] fill_level;
    logic                frame_valid;
    logic [COUNT_W-1:0]  overrun_total;
    logic [COUNT_W-1:0]  underrun_total;
    logic [COUNT_W-1:0]  written_total;
    logic [COUNT_W-1:0]  read_total;
  } status_t;

  typedef struct packed {
    op_t                               op;
    logic [ADDR_MAX_W-1:0]             addr;
    logic [LANES-1:0]                  lane_en;
    logic [LANES-1:0][SAMPLE_W-1:0]    samples;
    status_t                           status;
  } cmd_t;

endpackage

// File: rtl/mcorf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcorf_if
// Channel interfaces: frame requests in, frame results out, register writes.
// ----------------------------------------------------------------------------
interface mcorf_in_if;
  logic                            valid;
  logic                            ready;
  logic [mcorf_pkg::MODE_W-1:0]    mode;
  logic [mcorf_pkg::SAMPLE_W-1:0]  in_sample_0;
  logic [mcorf_pkg::SAMPLE_W-1:0]  in_sample_1;
  logic [mcorf_pkg::SAMPLE_W-1:0]  in_sample_2;
  logic [mcorf_pkg::SAMPLE_W-1:0]  in_sample_3;
  logic                            request_last;

  modport source (output valid, mode, in_sample_0, in_sample_1, in_sample_2,
                  in_sample_3, request_last, input ready);
  modport sink (input valid, mode, in_sample_0, in_sample_1, in_sample_2,
                in_sample_3, request_last, output ready);
endinterface

interface mcorf_out_if;
  logic                             valid;
  logic                             ready;
  logic [mcorf_pkg::SAMPLE_W-1:0]   out_sample_0;
  logic [mcorf_pkg::SAMPLE_W-1:0]   out_sample_1;
  logic [mcorf_pkg::SAMPLE_W-1:0]   out_sample_2;
  logic [mcorf_pkg::SAMPLE_W-1:0]   out_sample_3;
  logic                             frame_valid;
  logic [mcorf_pkg::FRAMES_W-1:0]   frames_delivered;
  logic [mcorf_pkg::FRAMES_W-1:0]   fill_level;
  logic [mcorf_pkg::COUNT_W-1:0]    overrun_total;
  logic [mcorf_pkg::COUNT_W-1:0]    underrun_total;
  logic [mcorf_pkg::COUNT_W-1:0]    written_total;
  logic [mcorf_pkg::COUNT_W-1:0]    read_total;

  modport source (output valid, out_sample_0, out_sample_1, out_sample_2,
                  out_sample_3, frame_valid, frames_delivered, fill_level,
                  overrun_total, underrun_total, written_total, read_total,
                  input ready);
  modport sink (input valid, out_sample_0, out_sample_1, out_sample_2,
                out_sample_3, frame_valid, frames_delivered, fill_level,
                overrun_total, underrun_total, written_total, read_total,
                output ready);
endinterface

interface mcorf_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mcorf_pkg::CFG_INDEX_W-1:0]  index;
  logic [mcorf_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/mcorf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcorf_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module mcorf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/mcorf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcorf_front
// Request front end: holds configuration, cursors, fill, packet and request
// tracking and the totals; turns each request into a storage command.
// ----------------------------------------------------------------------------
module mcorf_front #(
  parameter int CAPACITY     = 1024,
  parameter int MAX_CHANNELS = 4
) (
  input  logic              clk,
  input  logic              rst,
  mcorf_in_if.sink          item,
  mcorf_cfg_if.sink         cfg,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output mcorf_pkg::cmd_t   cmd
);
  import mcorf_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_MAX = CW'(CAPACITY);
  localparam logic [CHAN_W:0] CHAN_MAX = (CHAN_W + 1)'(MAX_CHANNELS);

  logic [CHAN_W-1:0]     channels_in_use;
  logic [CFG_DATA_W-1:0] capacity_frames;
  logic [AW-1:0]         write_cursor, write_cursor_next;
  logic [AW-1:0]         read_cursor, read_cursor_next;
  logic [CW-1:0]         fill_count, fill_count_next;
  logic [CW-1:0]         packet_frame_count, packet_frame_count_next;
  logic                  packet_overran, packet_overran_next;
  logic [FRAMES_W-1:0]   request_delivered, request_delivered_next;
  logic                  request_short, request_short_next;
  logic [COUNT_W-1:0]    overrun_counter, overrun_counter_next;
  logic [COUNT_W-1:0]    underrun_counter, underrun_counter_next;
  logic [COUNT_W-1:0]    written_counter, written_counter_next;
  logic [COUNT_W-1:0]    read_counter, read_counter_next;

  logic [CW-1:0]     cap_eff;
  logic [CHAN_W:0]   nch;
  logic [LANES-1:0]  lane_mask;
  logic              accept;

  always_comb begin
    if (capacity_frames == '0) begin
      cap_eff = CW'(1);
    end else if (32'(capacity_frames) > 32'(CAPACITY)) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = CW'(capacity_frames);
    end
    nch = ({1'b0, channels_in_use} > CHAN_MAX) ? CHAN_MAX : {1'b0, channels_in_use};
    for (int l = 0; l < LANES; l++) begin
      lane_mask[l] = (32'(l) < 32'(nch));
    end
  end

  assign item.ready = cmd_ready;
  assign cfg.ready  = 1'b1;
  assign accept     = item.valid & item.ready;
  assign cmd_valid  = accept;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] cur,
                                            input logic [CW-1:0] cap);
    logic [CW:0] n;
    n = (CW + 1)'(cur) + (CW + 1)'(1);
    return (n >= {1'b0, cap}) ? '0 : AW'(n);
  endfunction

  always_comb begin
    logic full;
    logic ovr;
    logic short_eff;
    logic rd_ok;
    logic [FRAMES_W-1:0] del;

    write_cursor_next       = write_cursor;
    read_cursor_next        = read_cursor;
    fill_count_next         = fill_count;
    packet_frame_count_next = packet_frame_count;
    packet_overran_next     = packet_overran;
    request_delivered_next  = request_delivered;
    request_short_next      = request_short;
    overrun_counter_next    = overrun_counter;
    underrun_counter_next   = underrun_counter;
    written_counter_next    = written_counter;
    read_counter_next       = read_counter;
    full      = (fill_count >= cap_eff);
    ovr       = packet_overran;
    short_eff = request_short;
    rd_ok     = (fill_count != '0);
    del       = '0;

    cmd         = '0;
    cmd.op      = OP_NONE;
    cmd.samples = {item.in_sample_3, item.in_sample_2, item.in_sample_1, item.in_sample_0};

    if (item.mode == MODE_WRITE && nch != '0) begin
      cmd.op      = OP_WRITE;
      cmd.addr    = ADDR_MAX_W'(write_cursor);
      cmd.lane_en = lane_mask;
      write_cursor_next = advance(write_cursor, cap_eff);
      if (full) begin
        read_cursor_next = advance(read_cursor, cap_eff);
        ovr = 1'b1;
      end else begin
        fill_count_next = fill_count + CW'(1);
      end
      if (packet_frame_count < cap_eff) begin
        packet_frame_count_next = packet_frame_count + CW'(1);
        written_counter_next    = written_counter + 1'b1;
      end else begin
        ovr = 1'b1;
      end
      packet_overran_next = ovr;
      if (item.request_last) begin
        if (ovr) begin
          overrun_counter_next = overrun_counter + 1'b1;
        end
        packet_frame_count_next = '0;
        packet_overran_next     = 1'b0;
      end
    end else if (item.mode == MODE_READ && nch != '0) begin
      del = request_delivered;
      if (rd_ok) begin
        cmd.op      = OP_READ;
        cmd.addr    = ADDR_MAX_W'(read_cursor);
        cmd.lane_en = lane_mask;
        read_cursor_next  = advance(read_cursor, cap_eff);
        fill_count_next   = fill_count - CW'(1);
        read_counter_next = read_counter + 1'b1;
        if (request_delivered != DELIVERED_MAX) begin
          del = request_delivered + 1'b1;
        end
      end else begin
        short_eff = 1'b1;
      end
      cmd.status.frame_valid      = rd_ok;
      cmd.status.frames_delivered = del;
      request_delivered_next = del;
      request_short_next     = short_eff;
      if (item.request_last) begin
        if (short_eff) begin
          underrun_counter_next = underrun_counter + 1'b1;
        end
        request_delivered_next = '0;
        request_short_next     = 1'b0;
      end
    end else if (item.mode == MODE_CLEAR) begin
      write_cursor_next = '0;
      read_cursor_next  = '0;
      fill_count_next   = '0;
    end

    cmd.status.fill_level     = FRAMES_W'(fill_count_next);
    cmd.status.overrun_total  = overrun_counter_next;
    cmd.status.underrun_total = underrun_counter_next;
    cmd.status.written_total  = written_counter_next;
    cmd.status.read_total     = read_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (cfg.valid && cfg.ready)) begin
      if (rst) begin
        channels_in_use <= CHAN_W'(2);
        capacity_frames <= CFG_DATA_W'(1024);
      end else begin
        unique case (cfg.index)
          CFG_CHANNELS: channels_in_use <= cfg.data[CHAN_W-1:0];
          CFG_CAPACITY: capacity_frames <= cfg.data;
          default: ;
        endcase
      end
      write_cursor       <= '0;
      read_cursor        <= '0;
      fill_count         <= '0;
      packet_frame_count <= '0;
      packet_overran     <= 1'b0;
      request_delivered  <= '0;
      request_short      <= 1'b0;
      overrun_counter    <= '0;
      underrun_counter   <= '0;
      written_counter    <= '0;
      read_counter       <= '0;
    end else if (accept) begin
      write_cursor       <= write_cursor_next;
      read_cursor        <= read_cursor_next;
      fill_count         <= fill_count_next;
      packet_frame_count <= packet_frame_count_next;
      packet_overran     <= packet_overran_next;
      request_delivered  <= request_delivered_next;
      request_short      <= request_short_next;
      overrun_counter    <= overrun_counter_next;
      underrun_counter   <= underrun_counter_next;
      written_counter    <= written_counter_next;
      read_counter       <= read_counter_next;
    end
  end

endmodule

// File: rtl/mcorf_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcorf_cmd_queue
// Two-entry command queue between the request front end and the storage
// back end.
// ----------------------------------------------------------------------------
module mcorf_cmd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  mcorf_pkg::cmd_t  push_cmd,
  output logic             pop_valid,
  input  logic             pop_ready,
  output mcorf_pkg::cmd_t  pop_cmd
);
  import mcorf_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = entry[rd_ptr];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entry[wr_ptr] <= push_cmd;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/mcorf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcorf_back
// Storage back end: one RAM per lane up to MAX_CHANNELS, issues frame writes and reads in
// command order and holds the result until it is taken.
// ----------------------------------------------------------------------------
module mcorf_back #(
  parameter int CAPACITY     = 1024,
  parameter int MAX_CHANNELS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  mcorf_pkg::cmd_t  cmd,
  mcorf_out_if.source      result
);
  import mcorf_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NL = (MAX_CHANNELS < LANES) ? MAX_CHANNELS : LANES;

  logic                           issue;
  logic                           pend_valid;
  status_t                        pend_status;
  logic [LANES-1:0]               pend_keep;
  logic [LANES-1:0][SAMPLE_W-1:0] rdata;
  logic [LANES-1:0][SAMPLE_W-1:0] sample;

  assign cmd_ready = ~pend_valid | result.ready;
  assign issue     = cmd_valid & cmd_ready;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    if (l < NL) begin : g_ram
      mcorf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (CAPACITY)
      ) u_ram (
        .clk   (clk),
        .we    (issue && cmd.op == OP_WRITE && cmd.lane_en[l]),
        .re    (issue && cmd.op == OP_READ),
        .addr  (cmd.addr[AW-1:0]),
        .wdata (cmd.samples[l]),
        .rdata (rdata[l])
      );
    end else begin : g_none
      assign rdata[l] = '0;
    end
    assign sample[l] = pend_keep[l] ? rdata[l] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (issue) begin
      pend_valid <= 1'b1;
    end else if (result.ready) begin
      pend_valid <= 1'b0;
    end
    if (issue) begin
      pend_status <= cmd.status;
      pend_keep   <= (cmd.op == OP_READ) ? cmd.lane_en : '0;
    end
  end

  assign result.valid            = pend_valid;
  assign result.out_sample_0     = sample[0];
  assign result.out_sample_1     = sample[1];
  assign result.out_sample_2     = sample[2];
  assign result.out_sample_3     = sample[3];
  assign result.frame_valid      = pend_status.frame_valid;
  assign result.frames_delivered = pend_status.frames_delivered;
  assign result.fill_level       = pend_status.fill_level;
  assign result.overrun_total    = pend_status.overrun_total;
  assign result.underrun_total   = pend_status.underrun_total;
  assign result.written_total    = pend_status.written_total;
  assign result.read_total       = pend_status.read_total;

endmodule

// File: rtl/multichannel_overwrite_ring_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_overwrite_ring_fifo
// Multichannel audio frame FIFO that overwrites the oldest frame when full.
//
//   channel  direction  carries
//   item     in         one request: write frame, read frame or clear
//   result   out        one result per request: samples, fill, totals
//   cfg      in         register write: channel count or capacity
//
// One request per cycle while the command queue has room; each taken request is
// held in the command queue and then in the back end's registered RAM read.
// A stalled result holds in the back end; the two-entry queue keeps taking
// requests until it fills. Reset clears control state only; the sample RAM
// has no clearing pass and each slot is read only after a write.
// ----------------------------------------------------------------------------
module multichannel_overwrite_ring_fifo #(
  parameter int CAPACITY     = 1024,
  parameter int MAX_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  mcorf_in_if.sink    item,
  mcorf_out_if.source result,
  mcorf_cfg_if.sink   cfg
);
  import mcorf_pkg::*;

  logic front_valid;
  logic front_ready;
  cmd_t front_cmd;
  logic back_valid;
  logic back_ready;
  cmd_t back_cmd;

  mcorf_front #(
    .CAPACITY     (CAPACITY),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg       (cfg),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  mcorf_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  mcorf_back #(
    .CAPACITY     (CAPACITY),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .result    (result)
  );

endmodule
